FILE: rtl/buffer_pool_page_replacement_macros.svh
// ----------------------------------------------------------------------------
// Buffer pool page replacement assertion macros
// Concurrent assertion forms for the buffer pool datapath.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_PAGE_REPLACEMENT_MACROS_SVH
`define BUFFER_POOL_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define BPPR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bppr_pkg.sv
// ----------------------------------------------------------------------------
// bppr_pkg
// Constants and controller/datapath interface types of the buffer pool.
// ----------------------------------------------------------------------------
package bppr_pkg;

  localparam int POOL_SLOTS = 16;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int RANK_W     = $clog2(POOL_SLOTS);
  localparam int COUNT_W    = $clog2(POOL_SLOTS + 1);
  localparam int CLK_STEPS  = 2 * POOL_SLOTS + 1;
  localparam int STEP_W     = $clog2(CLK_STEPS);
  localparam int PIN_W      = 8;
  localparam int TABLE_W    = 8;
  localparam int PAGE_W     = 16;
  localparam int READS_W    = 32;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 72;

  localparam logic [1:0] POLICY_CLOCK = 2'd0;
  localparam logic [1:0] POLICY_LRU   = 2'd1;
  localparam logic [1:0] POLICY_MRU   = 2'd2;

  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_PIN    = 2'd1;
  localparam logic [1:0] KIND_UNPIN  = 2'd2;

  localparam logic [2:0] REG_POLICY = 3'd0;

  typedef struct packed {
    logic capture;
    logic scan_init;
    logic scan_step;
    logic apply;
    logic out_load;
  } bppr_cmd_t;

  typedef struct packed {
    logic need_victim;
    logic scan_done;
    logic out_free;
  } bppr_status_t;

endpackage

FILE: rtl/bppr_ctrl.sv
// ----------------------------------------------------------------------------
// bppr_ctrl
// Request sequencer: capture, lookup, victim scan, update, result.
// ----------------------------------------------------------------------------
module bppr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  bppr_pkg::bppr_status_t status,
  output bppr_pkg::bppr_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (status.need_victim) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/bppr_datapath.sv
// ----------------------------------------------------------------------------
// bppr_datapath
// Slot tags, pin counts, reference bits, ranks, clock hand, victim scan
// and the result register.
// ----------------------------------------------------------------------------
`include "buffer_pool_page_replacement_macros.svh"

module bppr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bppr_pkg::bppr_cmd_t                   cmd,
  output bppr_pkg::bppr_status_t                status,
  input  logic [1:0]                            policy,
  input  logic [bppr_pkg::IN_W-1:0]             s_tdata,
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [bppr_pkg::OUT_W-1:0]            m_tdata
);

  localparam int N  = bppr_pkg::POOL_SLOTS;
  localparam int SW = bppr_pkg::SLOT_W;
  localparam int RW = bppr_pkg::RANK_W;

  logic [1:0]                     req_kind;
  logic [bppr_pkg::TABLE_W-1:0]   req_table;
  logic [bppr_pkg::PAGE_W-1:0]    req_page;

  logic [N-1:0]                   valid;
  logic [bppr_pkg::TABLE_W-1:0]   tag_table [N];
  logic [bppr_pkg::PAGE_W-1:0]    tag_page [N];
  logic [bppr_pkg::PIN_W-1:0]     pin [N];
  logic [N-1:0]                   refb;
  logic [RW-1:0]                  rank [N];
  logic [SW-1:0]                  hand;
  logic [bppr_pkg::READS_W-1:0]   read_counter;
  logic [bppr_pkg::COUNT_W-1:0]   res_count;

  logic [bppr_pkg::STEP_W-1:0]    scan_cnt;
  logic                           best_ok;
  logic [SW-1:0]                  best_idx;
  logic [RW-1:0]                  best_rank;

  logic                           r_hit;
  logic [SW-1:0]                  r_slot;
  logic                           r_loaded;
  logic                           r_ev;
  logic [bppr_pkg::TABLE_W-1:0]   r_evt;
  logic [bppr_pkg::PAGE_W-1:0]    r_evp;
  logic                           r_nov;

  logic                           found;
  logic [SW-1:0]                  hit_idx;
  logic                           free_ok;
  logic [SW-1:0]                  free_idx;
  logic                           access;
  logic                           clock_mode;
  logic                           largest;
  logic [SW-1:0]                  scan_idx;
  logic                           cand;
  logic                           take;
  logic                           better;
  logic [SW-1:0]                  hand_inc;
  logic                           load;
  logic [SW-1:0]                  tgt;

  always_comb begin
    found    = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (!found && valid[i] && tag_table[i] == req_table && tag_page[i] == req_page) begin
        found   = 1'b1;
        hit_idx = SW'(i);
      end
      if (!free_ok && !valid[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign access     = !req_kind[1];
  assign clock_mode = (policy == bppr_pkg::POLICY_CLOCK);
  assign largest    = (policy != bppr_pkg::POLICY_MRU);
  assign scan_idx   = clock_mode ? hand : scan_cnt[SW-1:0];
  assign cand       = valid[scan_idx] && (pin[scan_idx] == '0);
  assign take       = cand && !refb[scan_idx];
  assign better     = !best_ok || (largest ? (rank[scan_idx] > best_rank)
                                           : (rank[scan_idx] < best_rank));
  assign hand_inc   = (hand == SW'(N - 1)) ? '0 : hand + SW'(1);
  assign load       = access && !found && (free_ok || best_ok);
  assign tgt        = found ? hit_idx : (free_ok ? free_idx : best_idx);

  assign status.need_victim = access && !found && !free_ok;
  assign status.scan_done   = clock_mode
                            ? (take || scan_cnt == bppr_pkg::STEP_W'(bppr_pkg::CLK_STEPS - 1))
                            : (scan_cnt == bppr_pkg::STEP_W'(N - 1));
  assign status.out_free    = !m_tvalid || m_tready;

  // request capture, tags and result fields (no reset)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= s_tuser;
      req_table <= s_tdata[bppr_pkg::TABLE_W-1:0];
      req_page  <= s_tdata[bppr_pkg::TABLE_W +: bppr_pkg::PAGE_W];
    end
    if (cmd.apply && load) begin
      tag_table[tgt] <= req_table;
      tag_page[tgt]  <= req_page;
    end
    if (cmd.apply) begin
      r_hit    <= found;
      r_slot   <= found ? hit_idx : (load ? tgt : '0);
      r_loaded <= load;
      r_ev     <= load && !free_ok;
      r_evt    <= (load && !free_ok) ? tag_table[best_idx] : '0;
      r_evp    <= (load && !free_ok) ? tag_page[best_idx] : '0;
      r_nov    <= access && !found && !free_ok && !best_ok;
    end
    if (cmd.out_load) begin
      m_tdata <= {3'b000, res_count, read_counter, r_nov, r_evp, r_evt,
                  r_ev, r_loaded, r_slot, r_hit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      refb         <= '0;
      hand         <= '0;
      read_counter <= '0;
      res_count    <= '0;
      scan_cnt     <= '0;
      best_ok      <= 1'b0;
      best_idx     <= '0;
      best_rank    <= '0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < N; i++) begin
        pin[i]  <= '0;
        rank[i] <= '0;
      end
    end else begin
      if (cmd.capture || cmd.scan_init) begin
        scan_cnt <= '0;
        best_ok  <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_cnt <= scan_cnt + bppr_pkg::STEP_W'(1);
        if (clock_mode) begin
          hand <= hand_inc;
          if (take) begin
            best_ok  <= 1'b1;
            best_idx <= hand;
          end else if (cand) begin
            refb[hand] <= 1'b0;
          end
        end else if (cand && better) begin
          best_ok   <= 1'b1;
          best_idx  <= scan_idx;
          best_rank <= rank[scan_idx];
        end
      end
      if (cmd.apply) begin
        if (!access) begin
          if (found && req_kind == bppr_pkg::KIND_UNPIN && pin[hit_idx] != '0) begin
            pin[hit_idx] <= pin[hit_idx] - bppr_pkg::PIN_W'(1);
          end
        end else if (found || load) begin
          if (!found && free_ok) begin
            for (int i = 0; i < N; i++) begin
              if (valid[i]) begin
                rank[i] <= rank[i] + RW'(1);
              end
            end
            valid[tgt] <= 1'b1;
            res_count  <= res_count + bppr_pkg::COUNT_W'(1);
          end else begin
            for (int i = 0; i < N; i++) begin
              if (SW'(i) != tgt && valid[i] && rank[i] < rank[tgt]) begin
                rank[i] <= rank[i] + RW'(1);
              end
            end
          end
          rank[tgt] <= '0;
          refb[tgt] <= 1'b1;
          if (load) begin
            pin[tgt] <= (req_kind == bppr_pkg::KIND_PIN) ? bppr_pkg::PIN_W'(1) : '0;
            if (read_counter != '1) begin
              read_counter <= read_counter + bppr_pkg::READS_W'(1);
            end
          end else if (req_kind == bppr_pkg::KIND_PIN && pin[tgt] != '1) begin
            pin[tgt] <= pin[tgt] + bppr_pkg::PIN_W'(1);
          end
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `BPPR_ASSERT_SAME(a_victim_unpinned, clk, rst, cmd.apply && load && !free_ok, pin[best_idx] == '0 && valid[best_idx], "victim slot is pinned or empty")
  `BPPR_ASSERT_NEXT(a_reads_monotonic, clk, rst, 1'b1, read_counter >= $past(read_counter), "disk read counter went down")
  `BPPR_ASSERT_NEXT(a_fill_counts, clk, rst, cmd.apply && load && free_ok, res_count == $past(res_count) + bppr_pkg::COUNT_W'(1), "fill did not raise resident count")

endmodule

FILE: rtl/buffer_pool_page_replacement.sv
// A hit, free fill or unpin runs through the capture, lookup, apply and output states.
// Misses on a full pool add a victim scan: every slot for LRU/MRU, up to a victim for clock.
// Requests do not overlap: a new one is taken only in idle; the scan checks one slot per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous): all slots empty, ranks, pins, reference bits, hand,
// read counter and policy cleared; no clearing pass.
// ----------------------------------------------------------------------------
// buffer_pool_page_replacement
// Buffer pool page lookup with clock, LRU and MRU replacement and pinning.
// ----------------------------------------------------------------------------
module buffer_pool_page_replacement (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bppr_pkg::IN_W-1:0]    s_tdata,   // table_id, page_index
  input  logic [1:0]                   s_tuser,   // kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // hit, slot, loaded, evicted, evicted_table, evicted_page, no_victim,
  // disk_reads, resident_count, zero pad
  output logic [bppr_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [1:0]             policy;
  bppr_pkg::bppr_cmd_t    cmd;
  bppr_pkg::bppr_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bppr_pkg::REG_POLICY[2]) ? {30'd0, policy} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= bppr_pkg::POLICY_CLOCK;
    end else if (psel && penable && pwrite && pready && paddr[2] == bppr_pkg::REG_POLICY[2]) begin
      policy <= pwdata[1:0];
    end
  end

  bppr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bppr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .policy   (policy),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: verif/tb_buffer_pool_page_replacement.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buffer_pool_page_replacement
// Drives page requests into the buffer pool under clock, LRU, MRU and the
// spare policy code, with directed pool-full, all-pinned and pin saturation
// runs plus random traffic over a small working set. A local pool model
// predicts every result, and the monitor checks each result field by field.
// ----------------------------------------------------------------------------
module tb_buffer_pool_page_replacement;

  localparam int LIMIT_CYCLES = 2000000;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  table_id;
    logic [15:0] page_index;
  } request_t;

  typedef struct {
    logic        hit;
    logic [3:0]  slot;
    logic        loaded;
    logic        evicted;
    logic [7:0]  evicted_table;
    logic [15:0] evicted_page;
    logic        no_victim;
    logic [31:0] disk_reads;
    logic [4:0]  resident_count;
  } outcome_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [bppr_pkg::IN_W-1:0]   s_tdata;
  logic [1:0]                  s_tuser;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [bppr_pkg::OUT_W-1:0]  m_tdata;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [2:0]                  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_accepted;

  request_t  pending_requests[$];
  outcome_t  expected_outcomes[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_off_cycles;
  int        mismatch_count;
  int        cycle_count;

  // pool model
  logic [1:0]  pool_policy;
  logic        pool_valid[bppr_pkg::POOL_SLOTS];
  logic [7:0]  pool_table[bppr_pkg::POOL_SLOTS];
  logic [15:0] pool_page[bppr_pkg::POOL_SLOTS];
  int          pool_pins[bppr_pkg::POOL_SLOTS];
  logic        pool_ref[bppr_pkg::POOL_SLOTS];
  int          pool_rank[bppr_pkg::POOL_SLOTS];
  int          pool_hand;
  logic [31:0] pool_reads;

  buffer_pool_page_replacement DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void pool_reset();
    pool_policy = bppr_pkg::POLICY_CLOCK;
    for (int i = 0; i < bppr_pkg::POOL_SLOTS; i++) begin
      pool_valid[i] = 1'b0;
      pool_table[i] = '0;
      pool_page[i] = '0;
      pool_pins[i] = 0;
      pool_ref[i] = 1'b0;
      pool_rank[i] = 0;
    end
    pool_hand = 0;
    pool_reads = '0;
  endfunction

  function automatic void promote_slot(int s);
    for (int i = 0; i < bppr_pkg::POOL_SLOTS; i++)
      if (i != s && pool_valid[i] && pool_rank[i] < pool_rank[s])
        pool_rank[i]++;
    pool_rank[s] = 0;
  endfunction

  function automatic int rank_victim(bit largest);
    int best;
    best = -1;
    for (int i = 0; i < bppr_pkg::POOL_SLOTS; i++) begin
      if (!pool_valid[i] || pool_pins[i] != 0) continue;
      if (best < 0 || (largest ? pool_rank[i] > pool_rank[best]
                               : pool_rank[i] < pool_rank[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic int clock_victim();
    int h;
    h = pool_hand % bppr_pkg::POOL_SLOTS;
    for (int n = 0; n < 2 * bppr_pkg::POOL_SLOTS + 1; n++) begin
      if (pool_pins[h] == 0) begin
        if (!pool_ref[h]) begin
          pool_hand = (h + 1) % bppr_pkg::POOL_SLOTS;
          return h;
        end
        pool_ref[h] = 1'b0;
      end
      h = (h + 1) % bppr_pkg::POOL_SLOTS;
    end
    pool_hand = h;
    return -1;
  endfunction

  function automatic outcome_t serve_request(request_t r);
    outcome_t o;
    int s;
    int free_slot;
    int resident;
    o = '{default: '0};
    s = -1;
    resident = 0;
    for (int i = 0; i < bppr_pkg::POOL_SLOTS; i++)
      if (s < 0 && pool_valid[i] && pool_table[i] == r.table_id &&
          pool_page[i] == r.page_index)
        s = i;
    if (r.kind != bppr_pkg::KIND_ACCESS && r.kind != bppr_pkg::KIND_PIN) begin
      if (s >= 0) begin
        o.hit = 1'b1;
        o.slot = s[3:0];
        if (r.kind == bppr_pkg::KIND_UNPIN && pool_pins[s] != 0) pool_pins[s]--;
      end
    end else begin
      if (s >= 0) begin
        o.hit = 1'b1;
        promote_slot(s);
        pool_ref[s] = 1'b1;
      end else begin
        free_slot = -1;
        for (int i = 0; i < bppr_pkg::POOL_SLOTS; i++)
          if (free_slot < 0 && !pool_valid[i]) free_slot = i;
        if (free_slot >= 0) begin
          s = free_slot;
          for (int i = 0; i < bppr_pkg::POOL_SLOTS; i++)
            if (pool_valid[i]) pool_rank[i]++;
          pool_valid[s] = 1'b1;
          pool_rank[s] = 0;
        end else begin
          if (pool_policy == bppr_pkg::POLICY_CLOCK) s = clock_victim();
          else s = rank_victim(pool_policy != bppr_pkg::POLICY_MRU);
          if (s >= 0) begin
            o.evicted = 1'b1;
            o.evicted_table = pool_table[s];
            o.evicted_page = pool_page[s];
            promote_slot(s);
          end
        end
        if (s >= 0) begin
          pool_table[s] = r.table_id;
          pool_page[s] = r.page_index;
          pool_pins[s] = 0;
          pool_ref[s] = 1'b1;
          o.loaded = 1'b1;
          if (pool_reads != 32'hFFFF_FFFF) pool_reads++;
        end else begin
          o.no_victim = 1'b1;
        end
      end
      if (s >= 0) begin
        o.slot = s[3:0];
        if (r.kind == bppr_pkg::KIND_PIN && pool_pins[s] != 255) pool_pins[s]++;
      end
    end
    for (int i = 0; i < bppr_pkg::POOL_SLOTS; i++)
      if (pool_valid[i]) resident++;
    o.disk_reads = pool_reads;
    o.resident_count = resident[4:0];
    return o;
  endfunction

  // accept inputs, check outputs
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    request_t req;
    if (rst) begin
      cycle_count <= 0;
      in_accepted <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      in_accepted <= s_tvalid && s_tready;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got.hit = m_tdata[0];
        got.slot = m_tdata[4:1];
        got.loaded = m_tdata[5];
        got.evicted = m_tdata[6];
        got.evicted_table = m_tdata[14:7];
        got.evicted_page = m_tdata[30:15];
        got.no_victim = m_tdata[31];
        got.disk_reads = m_tdata[63:32];
        got.resident_count = m_tdata[68:64];
        if (expected_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.hit !== want.hit || got.slot !== want.slot ||
              got.loaded !== want.loaded || got.evicted !== want.evicted ||
              got.evicted_table !== want.evicted_table ||
              got.evicted_page !== want.evicted_page ||
              got.no_victim !== want.no_victim ||
              got.disk_reads !== want.disk_reads ||
              got.resident_count !== want.resident_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req.kind = s_tuser;
        req.table_id = s_tdata[7:0];
        req.page_index = s_tdata[23:8];
        expected_outcomes.insert(expected_outcomes.size(), serve_request(req));
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    logic     next_valid;
    request_t req;
    next_valid = s_tvalid;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!s_tvalid || in_accepted) begin
      next_valid = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        s_tdata <= {req.page_index, req.table_id};
        s_tuser <= req.kind;
        next_valid = 1'b1;
      end
    end
    s_tvalid <= next_valid;
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_policy(input logic [1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {bppr_pkg::REG_POLICY[0], 2'b00};
    pwdata <= {30'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_policy = value;
  endtask

  task automatic queue_request(input logic [1:0] kind, input logic [7:0] tbl,
                               input logic [15:0] page);
    request_t r;
    r.kind = kind;
    r.table_id = tbl;
    r.page_index = page;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic queue_random(input int count);
    int pick;
    logic [1:0] kind;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      kind = (pick < 65) ? bppr_pkg::KIND_ACCESS :
             (pick < 80) ? bppr_pkg::KIND_PIN : bppr_pkg::KIND_UNPIN;
      if ($urandom_range(9) == 0)
        queue_request(kind, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      else
        queue_request(kind, 8'($urandom_range(3)), 16'($urandom_range(23)));
    end
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    mismatch_count = 0;
    cycle_count = 0;
    pool_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill pinned, refuse on all pinned, extremes, unpin all
    write_policy(bppr_pkg::POLICY_LRU);
    for (int i = 0; i < 15; i++) queue_request(bppr_pkg::KIND_PIN, 8'd0, i[15:0]);
    queue_request(bppr_pkg::KIND_PIN, 8'd255, 16'hFFFF);
    queue_request(bppr_pkg::KIND_ACCESS, 8'd170, 16'h5555);
    queue_request(bppr_pkg::KIND_UNPIN, 8'd85, 16'hAAAA);
    queue_request(bppr_pkg::KIND_ACCESS, 8'd255, 16'hFFFF);
    for (int i = 0; i < 15; i++) queue_request(bppr_pkg::KIND_UNPIN, 8'd0, i[15:0]);
    queue_request(bppr_pkg::KIND_UNPIN, 8'd255, 16'hFFFF);
    queue_request(bppr_pkg::KIND_UNPIN, 8'd255, 16'hFFFF);
    queue_request(bppr_pkg::KIND_ACCESS, 8'd170, 16'h5555);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_policy(2'(phase % 4));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (phase == 2) hold_off_cycles = 400;
      queue_random(160);
      drain();
    end

    // pin count saturation and release
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_policy(bppr_pkg::POLICY_CLOCK);
    for (int i = 0; i < 258; i++) queue_request(bppr_pkg::KIND_PIN, 8'd7, 16'd7);
    queue_random(20);
    for (int i = 0; i < 258; i++) queue_request(bppr_pkg::KIND_UNPIN, 8'd7, 16'd7);
    queue_random(30);
    drain();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
